[hw/rtl/binary_dilation_3x3_assert.svh]
// assertion macros for the 3x3 binary dilation checker
`ifndef BINARY_DILATION_3X3_ASSERT_SVH
`define BINARY_DILATION_3X3_ASSERT_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define BD3_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("binary_dilation_3x3 check failed");

// next-cycle implication, sampled on clock, off while reset is high
`define BD3_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("binary_dilation_3x3 check failed");

`endif

[hw/rtl/bd3_pkg.sv]
// shared types, constants and window functions for the 3x3 binary dilation
package bd3_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int CFG_W          = 11;
   localparam int ROW_W          = 16;
   localparam int MASK_RST       = 186;
   localparam int WIDTH_RST      = 10;
   localparam int HEIGHT_RST     = 10;

   typedef enum logic [1:0] {
      REG_MASK   = 2'd0,
      REG_WIDTH  = 2'd1,
      REG_HEIGHT = 2'd2
   } bd3_reg_type;

   typedef struct packed {
      logic pix_set;
      logic row_start;
      logic has_top;
      logic has_mid;
      logic emit;
      logic last;
   } bd3_stage_type;

   // shift the window one column left, new column on the right
   function automatic logic [8:0] shift_in(input logic [8:0] win, input logic [2:0] col);
      logic [8:0] res;
      res = ((win >> 1) & 9'h0DB) | {col[2], 2'b00, col[1], 2'b00, col[0], 2'b00};
      return res;
   endfunction

   // right column only
   function automatic logic [8:0] place_right(input logic [2:0] col);
      logic [8:0] res;
      res = {col[2], 2'b00, col[1], 2'b00, col[0], 2'b00};
      return res;
   endfunction

   // bit k to bit 8-k
   function automatic logic [8:0] reverse9(input logic [8:0] v);
      logic [8:0] res;
      for (int k = 0; k < 9; k++) begin
         res[8 - k] = v[k];
      end
      return res;
   endfunction

endpackage

[hw/rtl/bd3_csr.sv]
// configuration registers with clamped image size and pixel count
module bd3_csr #(
   parameter int MAX_WIDTH  = bd3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bd3_pkg::MAX_HEIGHT_DEF,
   parameter int WW         = $clog2(MAX_WIDTH + 1),
   parameter int HW         = $clog2(MAX_HEIGHT + 1),
   parameter int PW         = WW + HW
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      write_en,
   input  logic [1:0]                write_index,
   input  logic [bd3_pkg::CFG_W-1:0] write_data,
   output logic [8:0]                mask,
   output logic [WW-1:0]             width,
   output logic [HW-1:0]             height,
   output logic [PW-1:0]             pixels,
   output logic                      hold
);

   localparam int XW    = (WW > bd3_pkg::CFG_W) ? WW : bd3_pkg::CFG_W;
   localparam int YW    = (HW > bd3_pkg::CFG_W) ? HW : bd3_pkg::CFG_W;
   localparam int W_RST = (bd3_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : bd3_pkg::WIDTH_RST;
   localparam int H_RST = (bd3_pkg::HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT
                                                              : bd3_pkg::HEIGHT_RST;

   logic [8:0]    mask_ff;
   logic [WW-1:0] width_ff,  width_in;
   logic [HW-1:0] height_ff, height_in;
   logic [PW-1:0] pixels_ff;
   logic          hold_ff;
   logic [XW-1:0] wx;
   logic [YW-1:0] hx;

   assign wx = XW'(write_data);
   assign hx = YW'(write_data);

   // zero counts as one, above the maximum counts as the maximum
   always_comb begin
      if (wx == '0) begin
         width_in = WW'(1);
      end else if (wx > XW'(MAX_WIDTH)) begin
         width_in = WW'(MAX_WIDTH);
      end else begin
         width_in = WW'(wx);
      end
      if (hx == '0) begin
         height_in = HW'(1);
      end else if (hx > YW'(MAX_HEIGHT)) begin
         height_in = HW'(MAX_HEIGHT);
      end else begin
         height_in = HW'(hx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= 9'(bd3_pkg::MASK_RST);
         width_ff  <= WW'(W_RST);
         height_ff <= HW'(H_RST);
         hold_ff   <= 1'b1;
      end else begin
         hold_ff <= write_en;
         if (write_en) begin
            case (write_index)
               bd3_pkg::REG_MASK:   mask_ff   <= write_data[8:0];
               bd3_pkg::REG_WIDTH:  width_ff  <= width_in;
               bd3_pkg::REG_HEIGHT: height_ff <= height_in;
               default: ;
            endcase
         end
      end
   end

   // pixel count is the registered product of the size registers
   always_ff @(posedge clock) begin
      pixels_ff <= PW'(width_ff) * PW'(height_ff);
   end

   assign mask   = mask_ff;
   assign width  = width_ff;
   assign height = height_ff;
   assign pixels = pixels_ff;
   assign hold   = hold_ff;

endmodule

[hw/rtl/bd3_linebuf.sv]
// two-row line buffer memory with write-to-read forwarding
module bd3_linebuf #(
   parameter int DEPTH = bd3_pkg::MAX_WIDTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_pix,
   output logic          above2,
   output logic          above1
);

   // bit 1: row two above, bit 0: row just above
   logic [1:0] line_ff [DEPTH];
   logic [1:0] rd_ff;
   logic [1:0] fwd_data_ff;
   logic       fwd_ff;
   logic [1:0] word;
   logic [1:0] wr_data;

   assign word    = fwd_ff ? fwd_data_ff : rd_ff;
   assign wr_data = {word[0], wr_pix};
   assign above2  = word[1];
   assign above1  = word[0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= line_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr_en && (rd_addr == wr_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_data_ff <= wr_data;
      end
   end

endmodule

[hw/rtl/bd3_window.sv]
// 3x3 window register and masked or of the dilation
module bd3_window (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  bd3_pkg::bd3_stage_type stage,
   input  logic                   above2,
   input  logic                   above1,
   input  logic [8:0]             mask,
   output logic                   dilated
);

   logic [8:0] window_ff, window_in;
   logic [8:0] shifted;
   logic [2:0] col;

   always_comb begin
      col = {stage.pix_set, above1 & stage.has_mid, above2 & stage.has_top};
      if (stage.row_start) begin
         // close the previous row with an empty right column
         shifted   = bd3_pkg::shift_in(window_ff, 3'b000);
         window_in = bd3_pkg::place_right(col);
      end else begin
         shifted   = bd3_pkg::shift_in(window_ff, col);
         window_in = shifted;
      end
      if (stage.emit && stage.last) begin
         window_in = '0;
      end
   end

   assign dilated = |(bd3_pkg::reverse9(shifted) & mask);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (advance) begin
         window_ff <= window_in;
      end
   end

endmodule

[hw/rtl/binary_dilation_3x3.sv]
// top level of the streaming 3x3 binary dilation
//
//   port group   direction   payload
//   req_         in          tdata[7:0] pixel, tuser[0] action
//   rsp_         out         tdata[0] dilated, tlast last_pixel
//   csr_         in          csr_index register, csr_wdata value
//
// one item per clock unless hold or a stalled result blocks the input; a result
// leaves via the stage register, matched to the registered line buffer read, then
// the output register; reset empties the pipeline; input is held off after reset
// and after each csr write while the pixel count register settles
// a stalled result holds the stage behind it; items that give no result still flow
module binary_dilation_3x3 #(
   parameter int MAX_WIDTH  = bd3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bd3_pkg::MAX_HEIGHT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] pixel
   input  logic [0:0]                req_tuser,   // [0] action
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,   // [0] dilated, [7:1] zero
   output logic                      rsp_tlast,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [bd3_pkg::CFG_W-1:0] csr_wdata
);

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int PW    = WW + HW;
   localparam int ROW_W = bd3_pkg::ROW_W;

   logic [8:0]    mask;
   logic [WW-1:0] width;
   logic [HW-1:0] height;
   logic [PW-1:0] pixels;
   logic          hold;

   logic [AW-1:0]    col_ff,   col_in;
   logic [ROW_W-1:0] row_ff,   row_in;
   logic [PW-1:0]    count_ff, count_in;
   logic [WW-1:0]    col_inc;
   logic [PW-1:0]    count_inc;
   logic             wrap;

   bd3_pkg::bd3_stage_type stage_in, stage_ff;
   logic [AW-1:0]          addr_ff;
   logic                   stage_valid_ff;
   logic                   stage_go;
   logic                   req_fire;

   logic out_valid_ff;
   logic out_dilated_ff;
   logic out_last_ff;
   logic dilated;
   logic above2, above1;

   assign csr_ready = 1'b1;

   bd3_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .WW         (WW),
      .HW         (HW),
      .PW         (PW)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .write_en    (csr_valid && csr_ready),
      .write_index (csr_index),
      .write_data  (csr_wdata),
      .mask        (mask),
      .width       (width),
      .height      (height),
      .pixels      (pixels),
      .hold        (hold)
   );

   assign stage_go   = stage_valid_ff && (!stage_ff.emit || !out_valid_ff || rsp_tready);
   assign req_tready = (!stage_valid_ff || stage_go) && !hold;
   assign req_fire   = req_tvalid && req_tready;

   // position, emit and end-of-image decisions for the incoming item
   always_comb begin
      col_inc   = WW'(col_ff) + WW'(1);
      wrap      = col_inc >= width;
      count_inc = count_ff + PW'(1);

      stage_in.pix_set   = !req_tuser[0] && (req_tdata != '0) && (row_ff < ROW_W'(height));
      stage_in.row_start = (col_ff == '0);
      stage_in.has_top   = (row_ff >= ROW_W'(2));
      stage_in.has_mid   = (row_ff != '0);
      stage_in.emit      = stage_in.has_top || ((row_ff == ROW_W'(1)) && !stage_in.row_start);
      stage_in.last      = stage_in.emit && (count_inc >= pixels);

      col_in   = wrap ? '0 : col_inc[AW-1:0];
      row_in   = (wrap && (row_ff != '1)) ? row_ff + ROW_W'(1) : row_ff;
      count_in = stage_in.emit ? count_inc : count_ff;
      if (stage_in.last) begin
         col_in   = '0;
         row_in   = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         count_ff <= '0;
      end else if (req_fire) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_fire) begin
         stage_valid_ff <= 1'b1;
      end else if (stage_go) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_ff <= stage_in;
         addr_ff  <= col_ff;
      end
   end

   bd3_linebuf #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_linebuf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .wr_en   (stage_go),
      .wr_addr (addr_ff),
      .wr_pix  (stage_ff.pix_set),
      .above2  (above2),
      .above1  (above1)
   );

   bd3_window u_window (
      .clock   (clock),
      .reset   (reset),
      .advance (stage_go),
      .stage   (stage_ff),
      .above2  (above2),
      .above1  (above1),
      .mask    (mask),
      .dilated (dilated)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (stage_go && stage_ff.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_go && stage_ff.emit) begin
         out_dilated_ff <= dilated;
         out_last_ff    <= stage_ff.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0000000, out_dilated_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

[hw/rtl/bd3_checker.sv]
// port checker for the 3x3 binary dilation, bound to the top level
`include "binary_dilation_3x3_assert.svh"

module bd3_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       csr_valid,
   input logic       csr_ready
);

   // a stalled result keeps its payload
   `BD3_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // no item is taken in the cycle after a csr write
   `BD3_ASSERT_NEXT(a_csr_hold, csr_valid && csr_ready, !req_tready)

   // nothing comes out right after reset
   `BD3_ASSERT_SAME(a_reset_empty, $past(reset), !rsp_tvalid)

   // a new result comes from a taken item, through the stage register
   `BD3_ASSERT_SAME(a_rsp_latency, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 2))

endmodule

bind binary_dilation_3x3 bd3_checker u_checker (.*);

[tb/sv/tb_binary_dilation_3x3.sv]
// testbench for the streaming 3x3 binary dilation: predicts every output pixel and checks the stream
module tb_binary_dilation_3x3;

   localparam int MAXW          = bd3_pkg::MAX_WIDTH_DEF;
   localparam int MAXH          = bd3_pkg::MAX_HEIGHT_DEF;
   localparam int CROSS_MASK    = 186;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int RUN_LIMIT     = 2000000;

   typedef struct packed {
      logic dilated;
      logic last_pixel;
   } dil_pix_type;

   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = '0;
   logic [0:0]                req_tuser  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [7:0]                rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [1:0]                csr_index  = '0;
   logic [bd3_pkg::CFG_W-1:0] csr_wdata  = '0;

   // predictor state
   bit          line_two_up [MAXW];
   bit          line_one_up [MAXW];
   logic [8:0]  win_bits  = '0;
   int unsigned col_pos   = 0;
   int unsigned row_pos   = 0;
   int unsigned pix_count = 0;
   logic [8:0]  cfg_mask   = 9'(CROSS_MASK);
   logic [10:0] cfg_width  = 11'd10;
   logic [10:0] cfg_height = 11'd10;

   dil_pix_type expected_pixels[$];

   bit send_gap_on = 1'b1;
   bit sink_gap_on = 1'b1;
   bit hold_armed  = 1'b0;
   int items_sent      = 0;
   int results_checked = 0;
   int images_done     = 0;
   int mismatches      = 0;

   binary_dilation_3x3 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [8:0] right_column(input logic [2:0] c);
      return {c[2], 2'b00, c[1], 2'b00, c[0], 2'b00};
   endfunction

   task automatic predict_item(input logic act, input logic [7:0] pix);
      int unsigned w, h, r, c;
      logic        v, top, mid;
      logic [2:0]  col_bits;
      logic [8:0]  shifted, nxt, flipped;
      logic        emit;
      dil_pix_type e;
      w = 32'(cfg_width);
      h = 32'(cfg_height);
      if (w < 1) w = 1;
      if (w > MAXW) w = MAXW;
      if (h < 1) h = 1;
      if (h > MAXH) h = MAXH;
      r = row_pos;
      c = col_pos;
      v = (!act && pix != 8'd0 && r < h);
      top = 1'b0;
      mid = 1'b0;
      if (c < MAXW) begin
         if (r >= 2) top = line_two_up[c];
         if (r >= 1) mid = line_one_up[c];
         line_two_up[c] = line_one_up[c];
         line_one_up[c] = v;
      end
      col_bits = {v, mid, top};
      // a new row closes the old one with an empty right column
      if (c == 0) begin
         shifted = (win_bits >> 1) & 9'h0DB;
         nxt = right_column(col_bits);
      end else begin
         shifted = ((win_bits >> 1) & 9'h0DB) | right_column(col_bits);
         nxt = shifted;
      end
      win_bits = nxt;
      emit = (r >= 2) || (r == 1 && c >= 1);
      c++;
      if (c >= w) begin
         c = 0;
         if (r < 32'hFFFF) r++;
      end
      col_pos = c;
      row_pos = r;
      if (emit) begin
         for (int k = 0; k < 9; k++) flipped[8 - k] = shifted[k];
         e.dilated = |(flipped & cfg_mask);
         if (pix_count + 1 >= w * h) begin
            e.last_pixel = 1'b1;
            win_bits = '0;
            col_pos = 0;
            row_pos = 0;
            pix_count = 0;
         end else begin
            e.last_pixel = 1'b0;
            pix_count++;
         end
         expected_pixels.push_back(e);
      end
   endtask

   task automatic send_item(input logic act, input logic [7:0] pix);
      int gap;
      gap = send_gap_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= pix;
      do @(posedge clock); while (!req_tready);
      predict_item(act, pix);
      items_sent++;
   endtask

   // stop offering, wait for every expected pixel, then let the pipeline empty
   task automatic settle_block();
      int n;
      n = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      if (expected_pixels.size() != 0) begin
         $display("%0t missing results: expected %0d more, actual none", $time,
                  expected_pixels.size());
         mismatches++;
         expected_pixels.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [8:0] m, input logic [10:0] w, input logic [10:0] h);
      bd3_pkg::bd3_reg_type idx;
      logic [10:0]          val;
      for (int i = 0; i < 3; i++) begin
         case (i)
            0: begin idx = bd3_pkg::REG_MASK;   val = {2'b00, m}; end
            1: begin idx = bd3_pkg::REG_WIDTH;  val = w; end
            default: begin idx = bd3_pkg::REG_HEIGHT; val = h; end
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= val;
         do @(posedge clock); while (!csr_ready);
         case (idx)
            bd3_pkg::REG_MASK:  cfg_mask = val[8:0];
            bd3_pkg::REG_WIDTH: cfg_width = val;
            default:            cfg_height = val;
         endcase
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int unsigned eff_size(input logic [10:0] v, input int unsigned lim);
      if (v == 11'd0) return 1;
      if (32'(v) > lim) return lim;
      return 32'(v);
   endfunction

   task automatic send_image(input int density, input bit noisy);
      int unsigned w, h;
      logic        act;
      logic [7:0]  pix;
      w = eff_size(cfg_width, MAXW);
      h = eff_size(cfg_height, MAXH);
      for (int unsigned i = 0; i < w * h; i++) begin
         act = noisy && ($urandom_range(0, 19) == 0);
         pix = ($urandom_range(0, 99) < density) ? 8'($urandom_range(1, 255)) : 8'd0;
         send_item(act, pix);
      end
      // flush tail, on noisy images partly pixels below the last row
      for (int unsigned i = 0; i <= w; i++) begin
         act = !(noisy && ($urandom_range(0, 9) < 3));
         send_item(act, 8'($urandom));
      end
   endtask

   task automatic close_open_image();
      while (row_pos != 0 || col_pos != 0) send_item(1'b1, 8'($urandom));
   endtask

   task automatic test_reset_config();
      send_image(35, 1'b0);
      settle_block();
   endtask

   task automatic test_directed();
      write_regs(9'h1FF, 11'd3, 11'd3);
      send_item(1'b0, 8'd255);
      send_item(1'b0, 8'd0);
      send_item(1'b0, 8'd1);
      send_item(1'b0, 8'd128);
      send_item(1'b1, 8'd255);
      send_item(1'b0, 8'd0);
      send_item(1'b0, 8'd0);
      send_item(1'b0, 8'd0);
      send_item(1'b0, 8'd127);
      send_item(1'b0, 8'd255);
      send_item(1'b1, 8'd0);
      send_item(1'b0, 8'd1);
      send_item(1'b1, 8'd255);
      settle_block();
      write_regs(9'h000, 11'd2, 11'd2);
      repeat (4) send_item(1'b0, 8'd255);
      repeat (3) send_item(1'b1, 8'd0);
      settle_block();
      write_regs(9'h010, 11'd4, 11'd1);
      send_item(1'b0, 8'd1);
      send_item(1'b0, 8'd0);
      send_item(1'b0, 8'd255);
      send_item(1'b0, 8'd0);
      repeat (5) send_item(1'b1, 8'd0);
      settle_block();
   endtask

   task automatic test_size_extremes();
      write_regs(9'(CROSS_MASK), 11'd0, 11'd0);
      send_image(50, 1'b0);
      settle_block();
      // oversized width: one full clamped row and the start of the next, then a narrow close
      write_regs(9'h1FF, 11'd2047, 11'd1);
      repeat (MAXW + 2) send_item(1'b0, 8'($urandom));
      settle_block();
      write_regs(9'h1FF, 11'd2, 11'd1);
      close_open_image();
      settle_block();
      write_regs(9'h0AA, 11'd1, 11'd2047);
      send_image(20, 1'b1);
      settle_block();
   endtask

   task automatic test_mid_image_change();
      write_regs(9'h0F3, 11'd8, 11'd6);
      repeat (21) send_item(1'b0, 8'($urandom));
      settle_block();
      write_regs(9'($urandom_range(0, 511)), 11'd5, 11'd7);
      close_open_image();
      settle_block();
   endtask

   task automatic test_back_pressure();
      send_gap_on = 1'b0;
      write_regs(9'(CROSS_MASK), 11'd8, 11'd8);
      hold_armed = 1'b1;
      send_image(40, 1'b0);
      settle_block();
      send_gap_on = 1'b1;
   endtask

   task automatic test_random_images(input int budget);
      int          stop_at;
      logic [8:0]  m;
      logic [10:0] w, h;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0: m = 9'h000;
            1: m = 9'h1FF;
            2: m = 9'(CROSS_MASK);
            default: m = 9'($urandom_range(0, 511));
         endcase
         w = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(13, 40))
                                         : 11'($urandom_range(1, 12));
         h = ($urandom_range(0, 19) == 0) ? 11'd0 : 11'($urandom_range(1, 8));
         send_gap_on = ($urandom_range(0, 3) != 0);
         sink_gap_on = ($urandom_range(0, 3) != 0);
         write_regs(m, w, h);
         send_image($urandom_range(5, 70), $urandom_range(0, 2) == 0);
         // broken ending: stray items start a new image that is flushed out
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 2 * w + 2)) send_item(1'($urandom), 8'($urandom));
            close_open_image();
         end
         settle_block();
      end
      send_gap_on = 1'b1;
      sink_gap_on = 1'b1;
   endtask

   initial begin : result_sink
      int stall;
      forever begin
         stall = sink_gap_on ? $urandom_range(0, 14) : 0;
         if (hold_armed) begin
            hold_armed = 1'b0;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin : result_check
      dil_pix_type e;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t unexpected result: expected none, actual data %0h last %0b",
                        $time, rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               e = expected_pixels.pop_front();
               results_checked++;
               if (rsp_tdata !== {7'd0, e.dilated}) begin
                  $display("%0t dilated mismatch: expected %0h actual %0h", $time,
                           {7'd0, e.dilated}, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tlast !== e.last_pixel) begin
                  $display("%0t last_pixel mismatch: expected %0b actual %0b", $time,
                           e.last_pixel, rsp_tlast);
                  mismatches++;
               end
               if (e.last_pixel) images_done++;
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_config();
      test_directed();
      test_size_extremes();
      test_mid_image_change();
      test_back_pressure();
      test_random_images(250);
      settle_block();
      $display("sent %0d items, checked %0d output pixels over %0d images", items_sent,
               results_checked, images_done);
      $display("covered reset config, size clamping, mid-image changes, back pressure, random masks");
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/bd3_pkg.sv
hw/rtl/bd3_csr.sv
hw/rtl/bd3_linebuf.sv
hw/rtl/bd3_window.sv
hw/rtl/binary_dilation_3x3.sv
hw/rtl/bd3_checker.sv
tb/sv/tb_binary_dilation_3x3.sv
